// ===== hw/rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Shared types, widths, operation codes and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ROOT_W      = 32;
	localparam int DEN_W       = 64;
	localparam int SUM_W       = DEN_W + 1;
	localparam int NUM_W       = 32 + 2 * FRAC_BITS;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = NUM_W;
	localparam int SQ_REM_W    = ROOT_W + 2;
	localparam int DIV_REM_W   = DEN_W + 1;

	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
	localparam logic [31:0] FIX_ONE = 32'd1 << FRAC_BITS;

	localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
	localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

	// Divisors used when the sum of squares overflows 64 bits.
	localparam logic [DEN_W-1:0] INV_DEN_SAT = DEN_W'(1) << (DEN_W - 2);
	localparam logic [DEN_W-1:0] NRM_DEN_SAT = DEN_W'(1) << ROOT_W;

	typedef enum logic [3:0] {
		MODE_ADD   = 4'd0,
		MODE_SUB   = 4'd1,
		MODE_NEG   = 4'd2,
		MODE_SCALE = 4'd3,
		MODE_MUL   = 4'd4,
		MODE_INV   = 4'd5,
		MODE_NORM  = 4'd6,
		MODE_MOD   = 4'd7,
		MODE_NRM   = 4'd8,
		MODE_ROT   = 4'd9
	} mode_t;

	typedef struct packed {
		logic        [3:0]  mode;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] b_w;
		logic signed [31:0] scale_factor;
	} req_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_w;
		logic        [30:0] scalar_out;
		logic               saturated;
	} rsp_t;

	// Per-item control and partial results that travel down the pipeline.
	typedef struct packed {
		logic [3:0]             mode;
		logic [3:0]             neg;
		logic [3:0][31:0]       res;
		logic [30:0]            sc;
		logic                   sat;
		logic                   zero;
		logic                   carry;
		logic [DEN_W-1:0]       rad;
		logic [3:0][NUM_W-1:0]  num;
		logic [DEN_W-1:0]       den;
		logic [ROOT_W-1:0]      root;
	} ctl_t;

	typedef logic [3:0][NUM_W-1:0] quo_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} clamp_t;

	function automatic clamp_t clamp32(input logic signed [65:0] v);
		clamp_t c;
		c.sat = 1'b0;
		c.val = v[31:0];
		if (v > WIDE_MAX) begin
			c.sat = 1'b1;
			c.val = INT_MAX;
		end else if (v < WIDE_MIN) begin
			c.sat = 1'b1;
			c.val = INT_MIN;
		end
		return c;
	endfunction

	// Applies a sign to an unsigned quotient and clamps to 32-bit signed.
	function automatic clamp_t clamp_mag(input logic [NUM_W-1:0] q, input logic neg);
		clamp_t c;
		c.sat = 1'b0;
		if (!neg) begin
			if (q > NUM_W'(INT_MAX)) begin
				c.sat = 1'b1;
				c.val = INT_MAX;
			end else begin
				c.val = q[31:0];
			end
		end else begin
			if (q > NUM_W'(INT_MIN)) begin
				c.sat = 1'b1;
				c.val = INT_MIN;
			end else begin
				c.val = ~q[31:0] + 32'd1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qalu_front.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU front end
// Four pipeline stages: products, sums and cross product, second cross
// product, then clamping and preparation of the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_front
	import qalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_valid,
	input  req_t up_req,
	output logic dn_valid,
	output ctl_t dn_ctl
);

	// Stage 1: all products of A with B (or with the scale factor).
	logic signed [31:0] a_in [4];
	logic signed [31:0] m_in [4];

	always_comb begin
		a_in[0] = up_req.a_x;
		a_in[1] = up_req.a_y;
		a_in[2] = up_req.a_z;
		a_in[3] = up_req.a_w;
		if (up_req.mode == MODE_SCALE) begin
			for (int j = 0; j < 4; j++) m_in[j] = up_req.scale_factor;
		end else begin
			m_in[0] = up_req.b_x;
			m_in[1] = up_req.b_y;
			m_in[2] = up_req.b_z;
			m_in[3] = up_req.b_w;
		end
	end

	logic               valid_s1;
	logic [3:0]         mode_s1;
	logic signed [31:0] a_s1 [4];
	logic signed [31:0] b_s1 [4];
	logic signed [63:0] prod_s1 [4][4];
	logic [63:0]        sq_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= up_req.mode;
			b_s1[0] <= up_req.b_x;
			b_s1[1] <= up_req.b_y;
			b_s1[2] <= up_req.b_z;
			b_s1[3] <= up_req.b_w;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]  <= a_in[i];
				sq_s1[i] <= 64'(a_in[i]) * 64'(a_in[i]);
				for (int j = 0; j < 4; j++) prod_s1[i][j] <= 64'(a_in[i]) * 64'(m_in[j]);
			end
		end
	end

	// Stage 2: simple results, Hamilton sums, first cross product, sum of squares.
	logic signed [63:0] fs1 [4][4];
	logic signed [65:0] pre [4];
	logic signed [65:0] dif [3];
	clamp_t             uvc [3];
	logic [SUM_W-1:0]   sum_sq;

	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) fs1[i][j] = prod_s1[i][j] >>> FRAC_BITS;
		sum_sq = '0;
		for (int i = 0; i < 4; i++) sum_sq = sum_sq + SUM_W'(sq_s1[i]);
		dif[0] = 66'(fs1[1][2]) - 66'(fs1[2][1]);
		dif[1] = 66'(fs1[2][0]) - 66'(fs1[0][2]);
		dif[2] = 66'(fs1[0][1]) - 66'(fs1[1][0]);
		for (int k = 0; k < 3; k++) uvc[k] = clamp32(dif[k]);
		for (int i = 0; i < 4; i++) pre[i] = '0;
		case (mode_s1)
			MODE_ADD: for (int i = 0; i < 4; i++) pre[i] = 66'(a_s1[i]) + 66'(b_s1[i]);
			MODE_SUB: for (int i = 0; i < 4; i++) pre[i] = 66'(a_s1[i]) - 66'(b_s1[i]);
			MODE_NEG: for (int i = 0; i < 4; i++) pre[i] = -66'(a_s1[i]);
			MODE_SCALE: for (int i = 0; i < 4; i++) pre[i] = 66'(fs1[i][i]);
			MODE_MUL: begin
				pre[0] = 66'(fs1[3][0]) + 66'(fs1[0][3]) + 66'(fs1[1][2]) - 66'(fs1[2][1]);
				pre[1] = 66'(fs1[3][1]) + 66'(fs1[1][3]) + 66'(fs1[2][0]) - 66'(fs1[0][2]);
				pre[2] = 66'(fs1[3][2]) + 66'(fs1[2][3]) + 66'(fs1[0][1]) - 66'(fs1[1][0]);
				pre[3] = 66'(fs1[3][3]) - 66'(fs1[0][0]) - 66'(fs1[1][1]) - 66'(fs1[2][2]);
			end
			default: ;
		endcase
	end

	logic               valid_s2;
	logic [3:0]         mode_s2;
	logic signed [31:0] a_s2 [4];
	logic signed [31:0] b_s2 [3];
	logic signed [65:0] pre_s2 [4];
	logic signed [31:0] uv_s2 [3];
	logic               uvsat_s2;
	logic [SUM_W-1:0]   sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			sum_s2   <= sum_sq;
			uvsat_s2 <= uvc[0].sat | uvc[1].sat | uvc[2].sat;
			for (int i = 0; i < 4; i++) begin
				a_s2[i]   <= a_s1[i];
				pre_s2[i] <= pre[i];
			end
			for (int k = 0; k < 3; k++) begin
				b_s2[k]  <= b_s1[k];
				uv_s2[k] <= uvc[k].val;
			end
		end
	end

	// Stage 3: products for the second cross product and the w term.
	logic               valid_s3;
	logic [3:0]         mode_s3;
	logic signed [31:0] a_s3 [4];
	logic signed [31:0] b_s3 [3];
	logic signed [65:0] pre_s3 [4];
	logic               uvsat_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic signed [63:0] cr_s3 [6];
	logic signed [63:0] wv_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3  <= mode_s2;
			sum_s3   <= sum_s2;
			uvsat_s3 <= uvsat_s2;
			for (int i = 0; i < 4; i++) begin
				a_s3[i]   <= a_s2[i];
				pre_s3[i] <= pre_s2[i];
			end
			for (int k = 0; k < 3; k++) begin
				b_s3[k]  <= b_s2[k];
				wv_s3[k] <= 64'(a_s2[3]) * 64'(uv_s2[k]);
			end
			cr_s3[0] <= 64'(a_s2[1]) * 64'(uv_s2[2]);
			cr_s3[1] <= 64'(a_s2[2]) * 64'(uv_s2[1]);
			cr_s3[2] <= 64'(a_s2[2]) * 64'(uv_s2[0]);
			cr_s3[3] <= 64'(a_s2[0]) * 64'(uv_s2[2]);
			cr_s3[4] <= 64'(a_s2[0]) * 64'(uv_s2[1]);
			cr_s3[5] <= 64'(a_s2[1]) * 64'(uv_s2[0]);
		end
	end

	// Stage 4: rotation sum, final clamp, norm, divider operands.
	logic signed [63:0] fcr [6];
	logic signed [63:0] fwv [3];
	logic signed [65:0] uuv [3];
	logic signed [65:0] fin [4];
	clamp_t             cl [4];
	logic [31:0]        mag [4];
	logic [31:0]        mdiv [4];
	logic               carry;
	ctl_t               nxt;

	always_comb begin
		for (int k = 0; k < 6; k++) fcr[k] = cr_s3[k] >>> FRAC_BITS;
		for (int k = 0; k < 3; k++) fwv[k] = wv_s3[k] >>> FRAC_BITS;
		uuv[0] = 66'(fcr[0]) - 66'(fcr[1]);
		uuv[1] = 66'(fcr[2]) - 66'(fcr[3]);
		uuv[2] = 66'(fcr[4]) - 66'(fcr[5]);
		for (int i = 0; i < 4; i++) fin[i] = pre_s3[i];
		if (mode_s3 == MODE_ROT) begin
			for (int k = 0; k < 3; k++)
				fin[k] = 66'(b_s3[k]) + (66'(fwv[k]) <<< 1) + (uuv[k] <<< 1);
			fin[3] = '0;
		end

		carry     = sum_s3[SUM_W-1];
		nxt       = '0;
		nxt.mode  = mode_s3;
		nxt.carry = carry;
		nxt.zero  = (sum_s3 == '0);
		nxt.rad   = sum_s3[DEN_W-1:0];
		for (int i = 0; i < 4; i++) begin
			cl[i]      = clamp32(fin[i]);
			nxt.res[i] = cl[i].val;
			nxt.sat    = nxt.sat | cl[i].sat;
			mag[i]     = a_s3[i][31] ? 32'(-a_s3[i]) : a_s3[i];
			mdiv[i]    = carry ? (mag[i] >> 2) : mag[i];
		end
		if (mode_s3 == MODE_ROT) nxt.sat = nxt.sat | uvsat_s3;

		if (mode_s3 == MODE_NORM) begin
			if (carry || ((sum_s3[DEN_W-1:0] >> FRAC_BITS) > 64'(MAX31))) begin
				nxt.sat = 1'b1;
				nxt.sc  = MAX31;
			end else begin
				nxt.sc = 31'(sum_s3[DEN_W-1:0] >> FRAC_BITS);
			end
		end

		if (mode_s3 == MODE_INV) begin
			nxt.den = carry ? INV_DEN_SAT : sum_s3[DEN_W-1:0];
			for (int i = 0; i < 4; i++) begin
				nxt.num[i] = NUM_W'(mdiv[i]) << (2 * FRAC_BITS);
				// The vector part of the inverse takes the conjugate sign.
				nxt.neg[i] = (i < 3) ? !a_s3[i][31] : a_s3[i][31];
			end
		end else if (mode_s3 == MODE_NRM) begin
			for (int i = 0; i < 4; i++) begin
				nxt.num[i] = NUM_W'(mag[i]) << FRAC_BITS;
				nxt.neg[i] = a_s3[i][31];
			end
		end
	end

	logic valid_s4;
	ctl_t ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (en) valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) ctl_s4 <= nxt;
	end

	assign dn_valid = valid_s4;
	assign dn_ctl   = ctl_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/qalu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU square root pipeline
// Integer square root of the sum of squares, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_sqrt
	import qalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_valid,
	input  ctl_t up_ctl,
	output logic dn_valid,
	output ctl_t dn_ctl
);

	logic                valid_s [SQRT_STAGES];
	ctl_t                ctl_s   [SQRT_STAGES];
	logic [SQ_REM_W-1:0] rem_s   [SQRT_STAGES];
	logic [ROOT_W-1:0]   root_s  [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic                v_prev;
		ctl_t                c_prev;
		logic [SQ_REM_W-1:0] r_prev;
		logic [ROOT_W-1:0]   q_prev;
		logic [SQ_REM_W-1:0] r_sh;
		logic [SQ_REM_W-1:0] trial;
		logic [SQ_REM_W-1:0] r_next;
		logic [ROOT_W-1:0]   q_next;

		if (k == 0) begin : g_head
			assign v_prev = up_valid;
			assign c_prev = up_ctl;
			assign r_prev = '0;
			assign q_prev = '0;
		end else begin : g_body
			assign v_prev = valid_s[k-1];
			assign c_prev = ctl_s[k-1];
			assign r_prev = rem_s[k-1];
			assign q_prev = root_s[k-1];
		end

		// Bring down the next pair of radicand bits and try root*4+1.
		always_comb begin
			r_sh  = {r_prev[ROOT_W-1:0], c_prev.rad[2*(ROOT_W-1-k) +: 2]};
			trial = {q_prev, 2'b01};
			if (r_sh >= trial) begin
				r_next = r_sh - trial;
				q_next = {q_prev[ROOT_W-2:0], 1'b1};
			end else begin
				r_next = r_sh;
				q_next = {q_prev[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else if (en) valid_s[k] <= v_prev;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k]  <= c_prev;
				rem_s[k]  <= r_next;
				root_s[k] <= q_next;
			end
		end
	end

	always_comb begin
		dn_ctl      = ctl_s[SQRT_STAGES-1];
		dn_ctl.root = root_s[SQRT_STAGES-1];
	end

	assign dn_valid = valid_s[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/qalu_div.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU divider pipeline
// Four restoring division lanes, one quotient bit per stage, for the inverse
// and normalize operations.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_div
	import qalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_valid,
	input  ctl_t up_ctl,
	output logic dn_valid,
	output ctl_t dn_ctl,
	output quo_t dn_quo
);

	logic [DEN_W-1:0] den_in;

	// Normalize divides by the root; inverse by the sum of squares.
	always_comb begin
		den_in = up_ctl.den;
		if (up_ctl.mode == MODE_NRM)
			den_in = up_ctl.carry ? NRM_DEN_SAT : DEN_W'(up_ctl.root);
	end

	logic                 valid_s [DIV_STAGES];
	ctl_t                 ctl_s   [DIV_STAGES];
	logic [DEN_W-1:0]     den_s   [DIV_STAGES];
	logic [DIV_REM_W-1:0] rem_s   [DIV_STAGES][4];
	logic [NUM_W-1:0]     quo_s   [DIV_STAGES][4];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic                 v_prev;
		ctl_t                 c_prev;
		logic [DEN_W-1:0]     d_prev;
		logic [DIV_REM_W-1:0] r_prev [4];
		logic [NUM_W-1:0]     q_prev [4];
		logic [DIV_REM_W-1:0] r_sh   [4];
		logic [DIV_REM_W-1:0] r_next [4];
		logic [NUM_W-1:0]     q_next [4];

		if (k == 0) begin : g_head
			assign v_prev = up_valid;
			assign c_prev = up_ctl;
			assign d_prev = den_in;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign r_prev[l] = '0;
				assign q_prev[l] = '0;
			end
		end else begin : g_body
			assign v_prev = valid_s[k-1];
			assign c_prev = ctl_s[k-1];
			assign d_prev = den_s[k-1];
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign r_prev[l] = rem_s[k-1][l];
				assign q_prev[l] = quo_s[k-1][l];
			end
		end

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				r_sh[l] = {r_prev[l][DEN_W-1:0], c_prev.num[l][NUM_W-1-k]};
				if (r_sh[l] >= {1'b0, d_prev}) begin
					r_next[l] = r_sh[l] - {1'b0, d_prev};
					q_next[l] = {q_prev[l][NUM_W-2:0], 1'b1};
				end else begin
					r_next[l] = r_sh[l];
					q_next[l] = {q_prev[l][NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[k] <= 1'b0;
			else if (en) valid_s[k] <= v_prev;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k] <= c_prev;
				den_s[k] <= d_prev;
				for (int l = 0; l < 4; l++) begin
					rem_s[k][l] <= r_next[l];
					quo_s[k][l] <= q_next[l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) dn_quo[l] = quo_s[DIV_STAGES-1][l];
	end

	assign dn_valid = valid_s[DIV_STAGES-1];
	assign dn_ctl   = ctl_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_alu.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU
// Fixed-point quaternion arithmetic: add, subtract, negate, scale, product,
// inverse, norm, modulus, normalize and vector rotation.
// ----------------------------------------------------------------------------
// The unit is a fully pipelined datapath that accepts one request per clock
// and returns exactly one response per request, in order. Every request takes
// the same path: four front-end stages (multipliers and sums), SQRT_STAGES
// square root stages, NUM_W divider stages and the output register. Data is
// Q16.16. The latency is set by the bit-per-stage square root and divider.
// When the response is not taken, the whole pipeline holds and req_ready
// drops.
`default_nettype none

module quaternion_alu
	import qalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic en;
	logic fe_valid;
	ctl_t fe_ctl;
	logic sq_valid;
	ctl_t sq_ctl;
	logic div_valid;
	ctl_t div_ctl;
	quo_t div_quo;

	assign en        = !rsp_valid || rsp_ready;
	assign req_ready = en;

	qalu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (req_valid),
		.up_req   (req),
		.dn_valid (fe_valid),
		.dn_ctl   (fe_ctl)
	);

	qalu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (fe_valid),
		.up_ctl   (fe_ctl),
		.dn_valid (sq_valid),
		.dn_ctl   (sq_ctl)
	);

	qalu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (sq_valid),
		.up_ctl   (sq_ctl),
		.dn_valid (div_valid),
		.dn_ctl   (div_ctl),
		.dn_quo   (div_quo)
	);

	logic [3:0][31:0] res;
	logic [30:0]      sc;
	logic             sat;
	clamp_t           lane [4];
	rsp_t             rsp_nxt;

	always_comb begin
		res = div_ctl.res;
		sc  = div_ctl.sc;
		sat = div_ctl.sat;
		for (int l = 0; l < 4; l++) lane[l] = clamp_mag(div_quo[l], div_ctl.neg[l]);
		case (div_ctl.mode)
			MODE_INV, MODE_NRM: begin
				// A zero quaternion has no inverse or direction; return the identity.
				if (div_ctl.zero) begin
					res    = '0;
					res[3] = FIX_ONE;
				end else begin
					for (int l = 0; l < 4; l++) begin
						res[l] = lane[l].val;
						sat    = sat | lane[l].sat;
					end
				end
			end
			MODE_MOD: begin
				if (div_ctl.carry || (div_ctl.root > ROOT_W'(MAX31))) begin
					sat = 1'b1;
					sc  = MAX31;
				end else begin
					sc = div_ctl.root[30:0];
				end
			end
			default: ;
		endcase
		rsp_nxt.r_x        = res[0];
		rsp_nxt.r_y        = res[1];
		rsp_nxt.r_z        = res[2];
		rsp_nxt.r_w        = res[3];
		rsp_nxt.scalar_out = sc;
		rsp_nxt.saturated  = sat;
	end

	logic rsp_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (en) rsp_valid_q <= div_valid;
	end

	always_ff @(posedge clk) begin
		if (en) rsp_q <= rsp_nxt;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// Norm and modulus are the only operations with a scalar result, and they
	// return a zero quaternion.
	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.scalar_out != 31'd0) |->
			(rsp.r_x == 32'sd0) && (rsp.r_y == 32'sd0) &&
			(rsp.r_z == 32'sd0) && (rsp.r_w == 32'sd0))
		else $error("quaternion result alongside a scalar result");

	// A zero quaternion inverts or normalizes to the identity.
	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && en && div_ctl.zero &&
		((div_ctl.mode == MODE_INV) || (div_ctl.mode == MODE_NRM)) |=>
			(rsp.r_w == FIX_ONE) && (rsp.r_x == 32'sd0) && !rsp.saturated)
		else $error("zero quaternion did not give the identity");

	// The square root leaving the root pipeline is never too large.
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid && !sq_ctl.carry |->
			(64'(sq_ctl.root) * 64'(sq_ctl.root)) <= sq_ctl.rad)
		else $error("square root exceeds radicand");
`endif

endmodule

`default_nettype wire

// ===== test/quaternion_alu_tb.sv =====
// ----------------------------------------------------------------------------
// Quaternion ALU testbench
// Drives directed and random requests through the valid/ready request channel,
// predicts in fixed point each response that has no given expected value,
// and checks responses in order under varying sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_alu_tb
	import qalu_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 250;
	localparam int RAND_ITEMS     = 300;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t e;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	rsp_t expected_rsp_q[$];
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   quiet_cycles = 0;
	int   checked = 0;
	int   mode_hits[16];

	quaternion_alu u_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// Fixed-point product, rounded toward minus infinity.
	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic [31:0] sat32(input longint v, inout bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return INT_MAX;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return INT_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic rsp_t quat_result(input req_t q);
		longint a[4], b[4], s, r[4], uv[3], uuv[3];
		logic [65:0] wide_sum;
		logic [63:0] sumsq, mag, den, root, sc;
		logic [127:0] num, quo;
		bit carry, hit;
		rsp_t o;
		a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z; a[3] = q.a_w;
		b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z; b[3] = q.b_w;
		s = q.scale_factor;
		hit = 1'b0;
		sc = 0;
		for (int i = 0; i < 4; i++) r[i] = 0;
		wide_sum = 0;
		for (int i = 0; i < 4; i++) wide_sum = wide_sum + 66'(a[i] * a[i]);
		carry = wide_sum[65:64] != 0;
		sumsq = wide_sum[63:0];
		case (q.mode)
			MODE_ADD: for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
			MODE_SUB: for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
			MODE_NEG: for (int i = 0; i < 4; i++) r[i] = -a[i];
			MODE_SCALE: for (int i = 0; i < 4; i++) r[i] = fx_mul(a[i], s);
			MODE_MUL: begin
				r[0] = fx_mul(a[3], b[0]) + fx_mul(a[0], b[3]) + fx_mul(a[1], b[2])
					- fx_mul(a[2], b[1]);
				r[1] = fx_mul(a[3], b[1]) + fx_mul(a[1], b[3]) + fx_mul(a[2], b[0])
					- fx_mul(a[0], b[2]);
				r[2] = fx_mul(a[3], b[2]) + fx_mul(a[2], b[3]) + fx_mul(a[0], b[1])
					- fx_mul(a[1], b[0]);
				r[3] = fx_mul(a[3], b[3]) - fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
					- fx_mul(a[2], b[2]);
			end
			MODE_INV: begin
				if (!carry && sumsq == 0) begin
					r[3] = longint'(FIX_ONE);
				end else begin
					for (int i = 0; i < 4; i++) begin
						mag = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
						den = sumsq;
						if (carry) begin
							mag = mag >> 2;
							den = INV_DEN_SAT;
						end
						num = {64'd0, mag} << (2 * FRAC_BITS);
						quo = num / {64'd0, den};
						if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
						r[i] = longint'(quo[63:0]);
						// Vector parts are conjugated, the scalar part keeps its sign.
						if ((i < 3) != (a[i] < 0)) r[i] = -r[i];
					end
				end
			end
			MODE_NORM: begin
				sc = carry ? 64'(MAX31) : sumsq >> FRAC_BITS;
				if (carry || sc > 64'(MAX31)) begin
					hit = 1'b1;
					sc = 64'(MAX31);
				end
			end
			MODE_MOD: begin
				sc = carry ? 64'(MAX31) : floor_sqrt(sumsq);
				if (carry || sc > 64'(MAX31)) begin
					hit = 1'b1;
					sc = 64'(MAX31);
				end
			end
			MODE_NRM: begin
				if (!carry && sumsq == 0) begin
					r[3] = longint'(FIX_ONE);
				end else begin
					root = carry ? NRM_DEN_SAT : floor_sqrt(sumsq);
					for (int i = 0; i < 4; i++) begin
						mag = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
						mag = (mag << FRAC_BITS) / root;
						r[i] = a[i] < 0 ? -longint'(mag) : longint'(mag);
					end
				end
			end
			MODE_ROT: begin
				uv[0] = sat32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), hit);
				uv[1] = sat32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), hit);
				uv[2] = sat32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), hit);
				for (int i = 0; i < 3; i++) uv[i] = longint'(signed'(uv[i][31:0]));
				uuv[0] = fx_mul(a[1], uv[2]) - fx_mul(a[2], uv[1]);
				uuv[1] = fx_mul(a[2], uv[0]) - fx_mul(a[0], uv[2]);
				uuv[2] = fx_mul(a[0], uv[1]) - fx_mul(a[1], uv[0]);
				for (int i = 0; i < 3; i++)
					r[i] = b[i] + 2 * fx_mul(a[3], uv[i]) + 2 * uuv[i];
			end
			default: ;
		endcase
		o.r_x = sat32(r[0], hit);
		o.r_y = sat32(r[1], hit);
		o.r_z = sat32(r[2], hit);
		o.r_w = sat32(r[3], hit);
		o.scalar_out = sc[30:0];
		o.saturated = hit;
		return o;
	endfunction

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(9))
			0: return INT_MAX;
			1: return INT_MIN;
			2, 3, 4: return $urandom;
			5: return 32'(signed'($urandom_range(8)) - 4) <<< FRAC_BITS;
			default: return 32'($urandom_range(32'h0003_FFFF)) - 32'h0001_FFFF;
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t q;
		q.mode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
		q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp(); q.a_w = rand_comp();
		q.b_x = rand_comp(); q.b_y = rand_comp(); q.b_z = rand_comp(); q.b_w = rand_comp();
		q.scale_factor = rand_comp();
		// Occasionally a zero quaternion A, to reach the identity case.
		if ($urandom_range(24) == 0) {q.a_x, q.a_y, q.a_z, q.a_w} = '0;
		return q;
	endfunction

	task automatic send_request(input req_t item, input bit typed, input rsp_t typed_rsp);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(typed ? typed_rsp : quat_result(item));
		mode_hits[item.mode]++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
	endtask

	// Response side: random backpressure, in-order checking and the watchdog.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected response %h", rsp);
				end else begin
					e = expected_rsp_q.pop_front();
					checked++;
					if (rsp.r_x !== e.r_x || rsp.r_y !== e.r_y || rsp.r_z !== e.r_z ||
							rsp.r_w !== e.r_w || rsp.scalar_out !== e.scalar_out ||
							rsp.saturated !== e.saturated) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp x=%h y=%h z=%h w=%h s=%h f=%b",
								e.r_x, e.r_y, e.r_z, e.r_w, e.scalar_out, e.saturated);
							$display("          act x=%h y=%h z=%h w=%h s=%h f=%b",
								rsp.r_x, rsp.r_y, rsp.r_z, rsp.r_w, rsp.scalar_out,
								rsp.saturated);
						end
					end
				end
			end
		end
	end

	initial begin
		vec_t vecs[$];
		vec_t v;
		rsp_t zero_rsp, ident_rsp;
		zero_rsp = '0;
		ident_rsp = '0;
		ident_rsp.r_w = FIX_ONE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		v.r = '0; v.r.mode = MODE_ADD; v.typed = 1; v.e = zero_rsp; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_ADD;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {4{INT_MAX}};
		{v.r.b_x, v.r.b_y, v.r.b_z, v.r.b_w} = {4{INT_MAX}};
		v.e = '0; {v.e.r_x, v.e.r_y, v.e.r_z, v.e.r_w} = {4{INT_MAX}}; v.e.saturated = 1;
		vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_SUB;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {4{INT_MIN}};
		{v.r.b_x, v.r.b_y, v.r.b_z, v.r.b_w} = {4{32'd1}};
		v.e = '0; {v.e.r_x, v.e.r_y, v.e.r_z, v.e.r_w} = {4{INT_MIN}}; v.e.saturated = 1;
		vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_NEG;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {4{INT_MIN}};
		v.e = '0; {v.e.r_x, v.e.r_y, v.e.r_z, v.e.r_w} = {4{INT_MAX}}; v.e.saturated = 1;
		vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_INV; v.e = ident_rsp; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_NRM; v.e = ident_rsp; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_NORM;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {4{INT_MIN}};
		v.e = '0; v.e.scalar_out = MAX31; v.e.saturated = 1; vecs.push_back(v);
		v.r.mode = MODE_MOD; vecs.push_back(v);
		v.r = '0; v.r.mode = 4'd12; v.r.a_x = INT_MAX; v.e = zero_rsp; vecs.push_back(v);
		v.r.mode = 4'd15; vecs.push_back(v);
		v.r.mode = 4'd10; vecs.push_back(v);
		// The remaining rows go through the predictor.
		v.typed = 0;
		v.r = '0; v.r.mode = MODE_SCALE;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {INT_MAX, INT_MIN, FIX_ONE, -FIX_ONE};
		v.r.scale_factor = INT_MIN; vecs.push_back(v);
		v.r.scale_factor = 32'h0000_8000; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_MUL;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000};
		{v.r.b_x, v.r.b_y, v.r.b_z, v.r.b_w} = {32'hFFFF_0000, 32'h0_8000, 32'h5_0000, 32'h1_0000};
		vecs.push_back(v);
		{v.r.b_x, v.r.b_y, v.r.b_z, v.r.b_w} = {4{INT_MIN}}; vecs.push_back(v);
		v.r.mode = MODE_INV; vecs.push_back(v);
		v.r.mode = MODE_NORM; vecs.push_back(v);
		v.r.mode = MODE_MOD; vecs.push_back(v);
		v.r.mode = MODE_NRM; vecs.push_back(v);
		v.r.mode = MODE_ROT; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_INV; v.r.a_x = 32'd1; vecs.push_back(v);
		v.r.mode = MODE_NRM; v.r.a_w = INT_MIN; vecs.push_back(v);
		v.r = '0; v.r.mode = MODE_ROT;
		{v.r.a_x, v.r.a_y, v.r.a_z, v.r.a_w} = {4{INT_MAX}};
		{v.r.b_x, v.r.b_y, v.r.b_z} = {INT_MIN, INT_MAX, INT_MIN}; vecs.push_back(v);
		v.r.mode = MODE_INV; vecs.push_back(v);

		foreach (vecs[i]) send_request(vecs[i].r, vecs[i].typed, vecs[i].e);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 53 : 0;
			recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 9 : 0;
			for (int n = 0; n < RAND_ITEMS; n++) send_request(rand_req(), 0, zero_rsp);
			// Let the pipeline empty completely before the next phase.
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses over all ten operations and undefined modes,", checked);
		$display("including saturation and zero-norm cases, under three idling patterns.");
		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
